/* design/rmst_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and merge function for the range min/max/sum tree.
package rmst_pkg;

  localparam int LEAVES  = 1024;
  localparam int IDX_W   = 10;                  // width of lo, hi and last_index
  localparam int NODE_W  = $clog2(2 * LEAVES);  // node address width
  localparam int PTR_W   = NODE_W + 1;          // query bounds reach 2*LEAVES
  localparam int DATA_W  = 32;
  localparam int NODE_BITS = 3 * DATA_W;

  localparam logic signed [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_SET   = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_QUERY = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_RD,
    ST_WR_LEAF,
    ST_WR_UP,
    ST_Q_LEFT,
    ST_Q_RIGHT,
    ST_Q_DONE
  } state_e;

  // sum in the low bits, then min, then max
  typedef struct packed {
    logic signed [DATA_W-1:0] mx;
    logic signed [DATA_W-1:0] mn;
    logic signed [DATA_W-1:0] sum;
  } node_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    node_t             wdata;
    logic [NODE_W-1:0] raddr;
  } ram_req_t;

  localparam node_t NODE_EMPTY = '{mx: INT_MIN, mn: INT_MAX, sum: '0};

  function automatic node_t node_merge(node_t a, node_t b);
    node_t r;
    r.sum = a.sum + b.sum;
    r.mn  = (b.mn < a.mn) ? b.mn : a.mn;
    r.mx  = (a.mx < b.mx) ? b.mx : a.mx;
    return r;
  endfunction

endpackage

/* design/range_min_max_sum_tree_top.sv */
`timescale 1ns / 1ps
// Top level of the range min/max/sum tree: ports, config register, output register.
//
// Keeps 1024 signed 32-bit elements in a binary tree of sum/min/max nodes
// held in one 2048 x 96-bit simple dual-port RAM (one read, one write port).
// Slave stream: one item per command (set range, add to range, query range).
// Master stream: one item per query, carrying sum, min and max of the range.
// Config channel: writes last_index; only write it while the block is idle.
//
// Throughput is bound by the single RAM read port; a command is taken only
// in the idle state, after the previous one has finished:
//   query:      reads the boundary nodes of each tree level walked, up to
//               log2(LEAVES)+1 = 11 levels, then a closing check and the
//               result; narrow ranges walk fewer levels.
//   set / add:  each element reads and writes its leaf, then walks its path up to the root.
//   empty set/add range or unused mode: no result.
// Reset: the RAM is swept to zero, one node per cycle, over all 2048 nodes;
// s_axis_tready stays low during the sweep, config writes are still taken.
// Stall: results sit in an output register, so the next command is accepted
// while a result waits; a second query stalls only when its own result is
// ready and the register is still full.
module range_min_max_sum_tree_top import rmst_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // config write: last_index
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IDX_W-1:0] cfg_data_i,
  // commands
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [55:0]      s_axis_tdata,  // mode[1:0], lo[11:2], hi[21:12], value[53:22], pad
  // results
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [95:0]      m_axis_tdata   // range_sum[31:0], range_min[63:32], range_max[95:64]
);

  logic [IDX_W-1:0] last_index_q, last_index_d;
  logic             out_valid_q, out_valid_d;
  node_t            out_q, out_d;

  ram_req_t         ram_req;
  logic [NODE_BITS-1:0] ram_rdata;

  logic             res_valid;
  logic             res_ready;
  node_t            res;

  assign cfg_ready_o  = 1'b1;
  assign last_index_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : last_index_q;

  rmst_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .mode_i       (s_axis_tdata[1:0]),
    .lo_i         (s_axis_tdata[11:2]),
    .hi_i         (s_axis_tdata[21:12]),
    .value_i      ($signed(s_axis_tdata[53:22])),
    .last_index_i (last_index_q),
    .ram_req_o    (ram_req),
    .ram_rdata_i  (node_t'(ram_rdata)),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  rmst_ram #(
    .ADDR_W (NODE_W),
    .DATA_W (NODE_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // output register: refill when empty or being drained this cycle
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_index_q <= IDX_W'(LEAVES - 1);
      out_valid_q  <= 1'b0;
    end else begin
      last_index_q <= last_index_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

/* design/rmst_ram.sv */
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM, one write and one registered read port.
module rmst_ram #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 96
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/rmst_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer: clearing pass, leaf-by-leaf path updates and the query walk.
module rmst_ctrl import rmst_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               mode_i,
  input  logic [IDX_W-1:0]         lo_i,
  input  logic [IDX_W-1:0]         hi_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [IDX_W-1:0]         last_index_i,
  output ram_req_t                 ram_req_o,
  input  node_t                    ram_rdata_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output node_t                    res_o
);

  state_e state_q, state_d;

  logic [NODE_W-1:0]        clr_q, clr_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [IDX_W-1:0]         end_q, end_d;
  logic [NODE_W-1:0]        node_q, node_d;
  node_t                    cur_q, cur_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic                     set_q, set_d;
  logic [PTR_W-1:0]         l_q, l_d;
  logic [PTR_W-1:0]         r_q, r_d;
  logic                     pend_q, pend_d;
  node_t                    acc_q, acc_d;

  logic [IDX_W-1:0]         top_idx;
  logic [IDX_W-1:0]         hi_clip;
  logic                     write_go;
  logic                     query_go;
  logic [NODE_W-1:0]        leaf_addr;
  logic [NODE_W-1:0]        parent;
  logic signed [DATA_W-1:0] leaf_val;
  node_t                    parent_node;
  logic [PTR_W-1:0]         r_dec;

  // range clipping against the live index limit and the store size
  assign top_idx  = (last_index_i > IDX_W'(LEAVES - 1)) ? IDX_W'(LEAVES - 1) : last_index_i;
  assign hi_clip  = (hi_i > top_idx) ? top_idx : hi_i;
  assign write_go = ((mode_i == MODE_SET) || (mode_i == MODE_ADD)) && (lo_i <= hi_clip);
  assign query_go = (mode_i == MODE_QUERY);

  assign leaf_addr   = NODE_W'(LEAVES) + NODE_W'(idx_q);
  assign parent      = node_q >> 1;
  assign leaf_val    = set_q ? val_q : (ram_rdata_i.sum + val_q);
  assign parent_node = node_merge(cur_q, ram_rdata_i);
  assign r_dec       = r_q[0] ? (r_q - PTR_W'(1)) : r_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (write_go) state_d = ST_WR_RD;
          else if (query_go) state_d = ST_Q_LEFT;
        end
      end
      ST_WR_RD:   state_d = ST_WR_LEAF;
      ST_WR_LEAF: state_d = ST_WR_UP;
      ST_WR_UP: begin
        if (parent == NODE_W'(1)) begin
          state_d = (idx_q == end_q) ? ST_IDLE : ST_WR_RD;
        end
      end
      ST_Q_LEFT:  state_d = (l_q < r_q) ? ST_Q_RIGHT : ST_Q_DONE;
      ST_Q_RIGHT: state_d = ST_Q_LEFT;
      ST_Q_DONE: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    clr_d       = clr_q;
    idx_d       = idx_q;
    end_d       = end_q;
    node_d      = node_q;
    cur_d       = cur_q;
    val_d       = val_q;
    set_d       = set_q;
    l_d         = l_q;
    r_d         = r_q;
    pend_d      = 1'b0;
    acc_d       = pend_q ? node_merge(acc_q, ram_rdata_i) : acc_q;
    ram_req_o   = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = acc_q;
    case (state_q)
      ST_CLEAR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = clr_q;
        ram_req_o.wdata = '0;
        clr_d           = clr_q + NODE_W'(1);
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          idx_d = lo_i;
          end_d = hi_clip;
          val_d = value_i;
          set_d = (mode_i == MODE_SET);
          l_d   = PTR_W'(lo_i) + PTR_W'(LEAVES);
          r_d   = PTR_W'(hi_clip) + PTR_W'(LEAVES) + PTR_W'(1);
          acc_d = NODE_EMPTY;
        end
      end
      ST_WR_RD: begin
        ram_req_o.raddr = leaf_addr;
        node_d          = leaf_addr;
      end
      ST_WR_LEAF: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = node_q;
        ram_req_o.wdata = '{mx: leaf_val, mn: leaf_val, sum: leaf_val};
        ram_req_o.raddr = node_q ^ NODE_W'(1);
        cur_d           = '{mx: leaf_val, mn: leaf_val, sum: leaf_val};
      end
      ST_WR_UP: begin
        // write the parent while fetching its sibling, never the same entry
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = parent;
        ram_req_o.wdata = parent_node;
        ram_req_o.raddr = parent ^ NODE_W'(1);
        cur_d           = parent_node;
        node_d          = parent;
        if ((parent == NODE_W'(1)) && (idx_q != end_q)) idx_d = idx_q + IDX_W'(1);
      end
      ST_Q_LEFT: begin
        if ((l_q < r_q) && l_q[0]) begin
          ram_req_o.raddr = l_q[NODE_W-1:0];
          l_d             = l_q + PTR_W'(1);
          pend_d          = 1'b1;
        end
      end
      ST_Q_RIGHT: begin
        if (r_q[0]) begin
          ram_req_o.raddr = r_dec[NODE_W-1:0];
          pend_d          = 1'b1;
        end
        l_d = l_q >> 1;
        r_d = r_dec >> 1;
      end
      ST_Q_DONE: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    end_q  <= end_d;
    node_q <= node_d;
    cur_q  <= cur_d;
    val_q  <= val_d;
    set_q  <= set_d;
    l_q    <= l_d;
    r_q    <= r_d;
    acc_q  <= acc_d;
  end

endmodule

/* design/rmst_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the range min/max/sum tree, bound to the top level.
module rmst_checker import rmst_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // a result is either an empty-range marker or has min not above max
  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($signed(m_axis_tdata[63:32]) <= $signed(m_axis_tdata[95:64])) ||
      ((m_axis_tdata[31:0] == '0) && (m_axis_tdata[63:32] == INT_MAX) &&
       (m_axis_tdata[95:64] == INT_MIN)))
    else $error("inconsistent min/max in result");

  // a new result is only produced at the end of a query, while busy
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while command port was idle");

  // a query command never completes in the cycle after its accept
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result one cycle after accept");

endmodule

bind range_min_max_sum_tree_top rmst_checker u_rmst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
